### sv/onc_pkg.sv
// ----------------------------------------------------------------------------
// onc_pkg
// Shared constants for the octahedral normal codec.
// ----------------------------------------------------------------------------
`default_nettype none

package onc_pkg;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

endpackage

`default_nettype wire

### sv/onc_divider.sv
// ----------------------------------------------------------------------------
// onc_divider
// Pipelined restoring divider, one quotient bit per stage, for
// round(num * 2^SHIFT / den) on unsigned values. It carries a sideband word.
// ----------------------------------------------------------------------------
`default_nettype none

module onc_divider
    import onc_pkg::*;
#(
    parameter int NUM_BITS  = 17,
    parameter int DEN_BITS  = 18,
    parameter int SHIFT     = 15,
    parameter int Q_BITS    = 18,
    parameter int SIDE_BITS = 1
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [NUM_BITS-1:0]  num,
    input  wire logic [DEN_BITS-1:0]  den,
    input  wire logic [SIDE_BITS-1:0] side_in,
    output logic                      out_valid,
    output logic [Q_BITS-1:0]         quo,
    output logic [SIDE_BITS-1:0]      side_out
);

    // Dividend = num*2^SHIFT + den/2; quotient bits from Q_BITS-1 down to 0.
    localparam int DVD_BITS = NUM_BITS + SHIFT + 1;
    localparam int REM_BITS = DEN_BITS + 1;

    logic [DVD_BITS-1:0]  dvd_reg  [Q_BITS+1];
    logic [DEN_BITS-1:0]  den_reg  [Q_BITS+1];
    logic [REM_BITS-1:0]  rem_reg  [Q_BITS+1];
    logic [Q_BITS-1:0]    q_reg    [Q_BITS+1];
    logic [SIDE_BITS-1:0] side_reg [Q_BITS+1];
    logic                 vld_reg  [Q_BITS+1];

    always_comb
    begin
        dvd_reg[0]  = ({{(SHIFT+1){1'b0}}, num} << SHIFT)
                      + {{(SHIFT+NUM_BITS-DEN_BITS+2){1'b0}}, den[DEN_BITS-1:1]};
        den_reg[0]  = den;
        rem_reg[0]  = '0;
        q_reg[0]    = '0;
        side_reg[0] = side_in;
        vld_reg[0]  = in_valid;
    end

    for (genvar s = 0; s < Q_BITS; s++)
    begin : g_stage
        localparam int BIT = Q_BITS - 1 - s;
        logic [REM_BITS+DVD_BITS-1:0] trial;
        logic [REM_BITS+DVD_BITS-1:0] dshift;
        logic [REM_BITS+DVD_BITS-1:0] acc;
        logic                         ge;
        always_comb
        begin
            acc    = {rem_reg[s], dvd_reg[s]};
            dshift = {{(REM_BITS+DVD_BITS-DEN_BITS){1'b0}}, den_reg[s]} << BIT;
            ge     = (BIT < DVD_BITS) && ((acc >> BIT) >=
                     {{(REM_BITS+DVD_BITS-DEN_BITS){1'b0}}, den_reg[s]});
            trial  = ge ? acc - dshift : acc;
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1]  <= trial[REM_BITS+DVD_BITS-1:DVD_BITS];
                dvd_reg[s+1]  <= trial[DVD_BITS-1:0];
                den_reg[s+1]  <= den_reg[s];
                q_reg[s+1]    <= q_reg[s] | (Q_BITS'(ge) << BIT);
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[Q_BITS];
    assign quo       = q_reg[Q_BITS];
    assign side_out  = side_reg[Q_BITS];

endmodule

`default_nettype wire

### sv/onc_isqrt.sv
// ----------------------------------------------------------------------------
// onc_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module onc_isqrt
#(
    parameter int N_BITS    = 34,
    parameter int SIDE_BITS = 1
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic [N_BITS-1:0]       n,
    input  wire logic [SIDE_BITS-1:0]    side_in,
    output logic                         out_valid,
    output logic [(N_BITS + 1) / 2 - 1:0] root,
    output logic [SIDE_BITS-1:0]         side_out
);

    localparam int R_BITS = (N_BITS + 1) / 2;

    logic [N_BITS-1:0]    rem_reg  [R_BITS+1];
    logic [R_BITS-1:0]    res_reg  [R_BITS+1];
    logic [SIDE_BITS-1:0] side_reg [R_BITS+1];
    logic                 vld_reg  [R_BITS+1];

    always_comb
    begin
        rem_reg[0]  = n;
        res_reg[0]  = '0;
        side_reg[0] = side_in;
        vld_reg[0]  = in_valid;
    end

    for (genvar s = 0; s < R_BITS; s++)
    begin : g_stage
        localparam int BIT = R_BITS - 1 - s;
        logic [2*R_BITS+1:0] trial;
        logic                ge;
        always_comb
        begin
            // Try setting this bit: (res + 2^BIT)^2 - res^2 = (2*res + 2^BIT) * 2^BIT.
            trial = (({2'b0, R_BITS'(0), res_reg[s]} << 1) |
                     ((2*R_BITS+2)'(1) << BIT)) << BIT;
            ge    = {{(2*R_BITS+2-N_BITS){1'b0}}, rem_reg[s]} >= trial;
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1]  <= ge ? rem_reg[s] - N_BITS'(trial) : rem_reg[s];
                res_reg[s+1]  <= res_reg[s] | (R_BITS'(ge) << BIT);
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[R_BITS];
    assign root      = res_reg[R_BITS];
    assign side_out  = side_reg[R_BITS];

endmodule

`default_nettype wire

### sv/octahedral_normal_codec_core.sv
// ----------------------------------------------------------------------------
// octahedral_normal_codec_core
// Octahedral normal encode and decode in signed fixed point.
// ----------------------------------------------------------------------------
// One transfer is taken every cycle while the output is not stalled; a result
// passes, with B = COMPONENT_BITS, through three front stages, B+1 square-root
// stages, B+2 divider stages and the output register. A back-pressured output
// stalls the whole pipeline in place.
`default_nettype none

module octahedral_normal_codec_core
    import onc_pkg::*;
#(
    parameter int COMPONENT_BITS = 16
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // tdata from bit 0: in_x, in_y, in_z
    input  wire logic [((3 * COMPONENT_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // tuser: opcode
    input  wire logic                        s_tuser,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // tdata from bit 0: out_x, out_y, out_z
    output logic [((3 * COMPONENT_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int B       = COMPONENT_BITS;
    localparam int TD_BITS = ((3 * B + 7) / 8) * 8;
    localparam int M_BITS  = B + 1;            // magnitudes up to 2^(B-1)
    localparam int S_BITS  = B + 2;            // L1 sum or root
    localparam int L_BITS  = 2 * B + 1;        // squared length
    localparam int R_BITS  = (L_BITS + 1) / 2;
    localparam int D_BITS  = (S_BITS > R_BITS) ? S_BITS : R_BITS;
    localparam int Q_BITS  = B + 2;
    localparam logic signed [B+1:0] ONE = (B+2)'(1) << (B - 1);

    logic en;
    logic out_full_reg;
    assign en       = !out_full_reg || m_tready;
    assign s_tready = en;

    // ---- stage 1: unpack, magnitudes, fold/unfold setup ----
    logic signed [B-1:0] a, b, c;
    assign a = s_tdata[B-1:0];
    assign b = s_tdata[2*B-1:B];
    assign c = s_tdata[3*B-1:2*B];

    logic [M_BITS-1:0] ma, mb, mc;
    assign ma = a[B-1] ? M_BITS'(-$signed({a[B-1], a})) : M_BITS'(a);
    assign mb = b[B-1] ? M_BITS'(-$signed({b[B-1], b})) : M_BITS'(b);
    assign mc = c[B-1] ? M_BITS'(-$signed({c[B-1], c})) : M_BITS'(c);

    // Per-item sideband: op, fold, signs, and magnitudes of the three parts.
    typedef struct packed {
        logic              op;
        logic              fold;
        logic              sx, sy, sz;
        logic [M_BITS-1:0] nx, ny, nz;
    } side_t;

    logic              v1_reg;
    side_t             s1_reg;
    logic [S_BITS-1:0] sum1_reg;
    side_t             s1_next;
    logic signed [B+1:0] dz;

    always_comb
    begin
        s1_next    = '0;
        s1_next.op = s_tuser;
        dz = ONE - $signed({1'b0, ma}) - $signed({1'b0, mb});
        if (s_tuser == OP_ENCODE)
        begin
            s1_next.fold = !(c > 0);
            s1_next.sx   = a[B-1];
            s1_next.sy   = b[B-1];
            s1_next.nx   = ma;
            s1_next.ny   = mb;
        end
        else
        begin
            s1_next.fold = dz[B+1];
            s1_next.sx   = a[B-1];
            s1_next.sy   = b[B-1];
            s1_next.sz   = dz[B+1];
            s1_next.nx   = dz[B+1] ? M_BITS'(ONE - $signed({1'b0, mb})) : ma;
            s1_next.ny   = dz[B+1] ? M_BITS'(ONE - $signed({1'b0, ma})) : mb;
            s1_next.nz   = dz[B+1] ? M_BITS'(-dz) : M_BITS'(dz);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_tvalid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg   <= s1_next;
            sum1_reg <= S_BITS'(ma) + S_BITS'(mb) + S_BITS'(mc);
        end
    end

    // ---- stage 2: squares ----
    logic              v2_reg;
    side_t             s2_reg;
    logic [S_BITS-1:0] sum2_reg;
    logic [L_BITS-1:0] sqx_reg, sqy_reg, sqz_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg   <= s1_reg;
            sum2_reg <= sum1_reg;
            sqx_reg  <= L_BITS'(s1_reg.nx * s1_reg.nx);
            sqy_reg  <= L_BITS'(s1_reg.ny * s1_reg.ny);
            sqz_reg  <= L_BITS'(s1_reg.nz * s1_reg.nz);
        end
    end

    // ---- stage 3: length sum ----
    logic              v3_reg;
    side_t             s3_reg;
    logic [S_BITS-1:0] sum3_reg;
    logic [L_BITS:0]   l2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg   <= s2_reg;
            sum3_reg <= sum2_reg;
            l2_reg   <= (L_BITS+1)'(sqx_reg) + (L_BITS+1)'(sqy_reg) + (L_BITS+1)'(sqz_reg);
        end
    end

    // ---- square root (encode items pass through it with their sum) ----
    localparam int SQ_N   = L_BITS + 1;
    localparam int SQ_R   = (SQ_N + 1) / 2;
    localparam int SIDE_W = $bits(side_t) + S_BITS;

    logic              vq;
    logic [SQ_R-1:0]   root;
    logic [SIDE_W-1:0] sq_side;
    onc_isqrt #(.N_BITS(SQ_N), .SIDE_BITS(SIDE_W)) u_isqrt
    (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v3_reg), .n(l2_reg),
        .side_in({s3_reg, sum3_reg}), .out_valid(vq), .root(root), .side_out(sq_side)
    );

    side_t             s4;
    logic [S_BITS-1:0] sum4;
    assign {s4, sum4} = sq_side;

    logic [D_BITS-1:0] den;
    assign den = (s4.op == OP_ENCODE) ? D_BITS'(sum4) : D_BITS'(root);

    // ---- three dividers in parallel ----
    logic              vdx, vdy, vdz;
    logic [Q_BITS-1:0] qx, qy, qz;
    logic [$bits(side_t)-1:0] dside;
    logic              dzero_in, dzero_x, dzero_y, dzero_z;
    logic [D_BITS-1:0] den_safe;
    assign dzero_in = (den == '0);
    assign den_safe = dzero_in ? D_BITS'(1) : den;

    onc_divider #(.NUM_BITS(M_BITS), .DEN_BITS(D_BITS), .SHIFT(B-1), .Q_BITS(Q_BITS),
                  .SIDE_BITS($bits(side_t)+1)) u_div_x
    (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(vq), .num(s4.nx), .den(den_safe),
        .side_in({s4, dzero_in}), .out_valid(vdx), .quo(qx), .side_out({dside, dzero_x})
    );
    onc_divider #(.NUM_BITS(M_BITS), .DEN_BITS(D_BITS), .SHIFT(B-1), .Q_BITS(Q_BITS),
                  .SIDE_BITS(1)) u_div_y
    (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(vq), .num(s4.ny), .den(den_safe),
        .side_in(dzero_in), .out_valid(vdy), .quo(qy), .side_out(dzero_y)
    );
    onc_divider #(.NUM_BITS(M_BITS), .DEN_BITS(D_BITS), .SHIFT(B-1), .Q_BITS(Q_BITS),
                  .SIDE_BITS(1)) u_div_z
    (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(vq), .num(s4.nz), .den(den_safe),
        .side_in(dzero_in), .out_valid(vdz), .quo(qz), .side_out(dzero_z)
    );

    // ---- final stage: fold for encode, signs, saturation ----
    side_t sd;
    assign sd = dside;

    function automatic logic [B-1:0] sat(input logic neg, input logic [Q_BITS-1:0] m);
        logic [Q_BITS-1:0] lim;
        lim = (Q_BITS'(1) << (B - 1));
        if (neg)
            sat = (m >= lim) ? B'(lim) : B'(-m);
        else
            sat = (m >= lim) ? B'(lim - 1) : B'(m);
    endfunction

    logic [Q_BITS-1:0] ux, uy, uz;
    logic              nx_s, ny_s, nz_s;
    logic [B-1:0]      rx, ry, rz;
    always_comb
    begin
        ux = dzero_x ? '0 : qx;
        uy = dzero_y ? '0 : qy;
        uz = dzero_z ? '0 : qz;
        nx_s = sd.sx;
        ny_s = sd.sy;
        nz_s = sd.sz;
        if (sd.op == OP_ENCODE)
        begin
            uz = '0;
            if (sd.fold)
            begin
                ux = (Q_BITS'(1) << (B - 1)) - uy;
                uy = (Q_BITS'(1) << (B - 1)) - (dzero_x ? '0 : qx);
            end
        end
        rx = sat(nx_s && ux != '0, ux);
        ry = sat(ny_s && uy != '0, uy);
        rz = sat(nz_s && uz != '0, uz);
    end

    logic [TD_BITS-1:0] out_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_full_reg <= 1'b0;
        else if (en)
            out_full_reg <= vdx;
    end
    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= TD_BITS'({rz, ry, rx});
    end

    assign m_tvalid = out_full_reg;
    assign m_tdata  = out_reg;

    // The three dividers run in lock step.
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (vdx == vdy) && (vdy == vdz)) else $error("divider lanes out of step");
    // A stalled result holds its data.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed under stall");
    // Ready falls only while a result waits.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid) else $error("input stalled without a waiting result");

endmodule

`default_nettype wire
